### design/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int COUNT_BITS = 32;
    localparam int CMP_BITS   = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    localparam int CFG_DATA_BITS = 32;
    localparam int LEN_BITS      = 32;

    localparam logic [7:0] CHR_EXT = 8'h3B;
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_LF  = 8'h0A;

    localparam logic [2:0] PH_SIZE      = 3'd0;
    localparam logic [2:0] PH_EXT       = 3'd1;
    localparam logic [2:0] PH_DATA      = 3'd2;
    localparam logic [2:0] PH_DATA_END  = 3'd3;
    localparam logic [2:0] PH_FINAL_END = 3'd4;
    localparam logic [2:0] PH_STOP      = 3'd5;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BIG  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic CFG_MAX_BODY = 1'b0;
    localparam logic CFG_LIMIT_EN = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] MAX_BODY_RESET = 32'd1048576;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

### design/http_chunked_body_decoder.sv
`default_nettype none
// Decodes an HTTP/1.1 chunked body one byte per cycle: a hex size line
// (extensions after ';' skipped up to CR LF), that many data bytes, then CR LF;
// a zero size must be followed at once by CR LF and ends the message. Every
// accepted byte gives exactly one result item in the next cycle, carrying the
// body byte if it was chunk data, the status (in progress, complete, payload
// too large, malformed) and the running body length. Throughput is one byte
// per clock: all decoding is a single pass from the input port into the result
// register, and the input is stalled only while a result waits on a stalled
// output. Once the status leaves in progress, bytes are ignored until an item
// with start_req set begins a new message. Registers: index 0 is the body size
// limit, index 1 enables the limit check; write them only while idle.
module http_chunked_body_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_start_req,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [7:0]                             o_body_byte,
    output logic                                   o_body_valid,
    output logic [1:0]                             o_status,
    output logic [hcbd_pkg::LEN_BITS-1:0]          o_body_length,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [hcbd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import hcbd_pkg::*;

    logic [CFG_DATA_BITS-1:0] r_max_body;
    logic                     r_limit_en;

    logic [2:0]            r_phase;
    logic [SIZE_BITS-1:0]  r_chunk_left;
    logic [COUNT_BITS-1:0] r_body_count;
    logic [1:0]            r_final_status;
    logic                  r_digit_seen;
    logic                  r_cr_seen;

    logic [2:0]            n_phase;
    logic [SIZE_BITS-1:0]  n_chunk_left;
    logic [COUNT_BITS-1:0] n_body_count;
    logic [1:0]            n_final_status;
    logic                  n_digit_seen;
    logic                  n_cr_seen;
    logic                  n_body_valid;

    logic in_take;
    t_hex hex;

    assign o_stall = o_valid & i_stall;
    assign in_take = i_valid & ~o_stall;
    assign hex     = hex_decode(i_data_byte);

    always_comb begin
        n_phase        = r_phase;
        n_chunk_left   = r_chunk_left;
        n_body_count   = r_body_count;
        n_final_status = r_final_status;
        n_digit_seen   = r_digit_seen;
        n_cr_seen      = r_cr_seen;
        n_body_valid   = 1'b0;
        if (i_start_req) begin
            n_phase        = PH_SIZE;
            n_chunk_left   = '0;
            n_body_count   = '0;
            n_final_status = ST_BUSY;
            n_digit_seen   = 1'b0;
            n_cr_seen      = 1'b0;
        end
        if (n_final_status == ST_BUSY) begin
            case (n_phase)
                PH_SIZE: begin
                    if (n_cr_seen) begin
                        if (i_data_byte == CHR_LF) begin
                            n_cr_seen    = 1'b0;
                            n_digit_seen = 1'b0;
                            n_phase      = (n_chunk_left == '0) ? PH_FINAL_END : PH_DATA;
                        end else begin
                            n_final_status = ST_BAD;
                            n_phase        = PH_STOP;
                            n_cr_seen      = 1'b0;
                        end
                    end else if (i_data_byte == CHR_CR || i_data_byte == CHR_EXT) begin
                        if (!n_digit_seen) begin
                            n_final_status = ST_BAD;
                            n_phase        = PH_STOP;
                        end else if (i_data_byte == CHR_CR) begin
                            n_cr_seen = 1'b1;
                        end else begin
                            n_phase = PH_EXT;
                        end
                    end else if (!hex.ok || n_chunk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_final_status = ST_BAD;
                        n_phase        = PH_STOP;
                    end else begin
                        n_chunk_left = {n_chunk_left[SIZE_BITS-5:0], hex.value};
                        n_digit_seen = 1'b1;
                    end
                end
                PH_EXT: begin
                    if (n_cr_seen && i_data_byte == CHR_LF) begin
                        n_cr_seen    = 1'b0;
                        n_digit_seen = 1'b0;
                        n_phase      = (n_chunk_left == '0) ? PH_FINAL_END : PH_DATA;
                    end else begin
                        n_cr_seen = (i_data_byte == CHR_CR);
                    end
                end
                PH_DATA: begin
                    if (n_body_count == {COUNT_BITS{1'b1}} ||
                        (r_limit_en && CMP_BITS'(n_body_count) >= CMP_BITS'(r_max_body))) begin
                        n_final_status = ST_BIG;
                        n_phase        = PH_STOP;
                        n_cr_seen      = 1'b0;
                    end else begin
                        n_body_count = n_body_count + 1'b1;
                        n_body_valid = 1'b1;
                        n_chunk_left = n_chunk_left - 1'b1;
                        if (n_chunk_left == '0) begin
                            n_phase   = PH_DATA_END;
                            n_cr_seen = 1'b0;
                        end
                    end
                end
                PH_DATA_END, PH_FINAL_END: begin
                    if (!n_cr_seen) begin
                        if (i_data_byte == CHR_CR) begin
                            n_cr_seen = 1'b1;
                        end else begin
                            n_final_status = ST_BAD;
                            n_phase        = PH_STOP;
                        end
                    end else if (i_data_byte == CHR_LF) begin
                        n_cr_seen = 1'b0;
                        if (n_phase == PH_FINAL_END) begin
                            n_final_status = ST_DONE;
                            n_phase        = PH_STOP;
                        end else begin
                            n_phase      = PH_SIZE;
                            n_chunk_left = '0;
                            n_digit_seen = 1'b0;
                        end
                    end else begin
                        n_final_status = ST_BAD;
                        n_phase        = PH_STOP;
                        n_cr_seen      = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
            r_limit_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_BODY: r_max_body <= i_cfg_data;
                CFG_LIMIT_EN: r_limit_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIZE;
            r_chunk_left   <= '0;
            r_body_count   <= '0;
            r_final_status <= ST_BUSY;
            r_digit_seen   <= 1'b0;
            r_cr_seen      <= 1'b0;
        end else if (in_take) begin
            r_phase        <= n_phase;
            r_chunk_left   <= n_chunk_left;
            r_body_count   <= n_body_count;
            r_final_status <= n_final_status;
            r_digit_seen   <= n_digit_seen;
            r_cr_seen      <= n_cr_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (in_take) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            o_body_byte   <= n_body_valid ? i_data_byte : 8'd0;
            o_body_valid  <= n_body_valid;
            o_status      <= n_final_status;
            o_body_length <= LEN_BITS'(n_body_count);
        end
    end

endmodule
`default_nettype wire

### design/hcbd_checker.sv
`default_nettype none
module hcbd_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic [7:0]                         o_body_byte,
    input wire logic                               o_body_valid,
    input wire logic [1:0]                         o_status,
    input wire logic [hcbd_pkg::LEN_BITS-1:0]      o_body_length
);
    import hcbd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_body_byte) && $stable(o_status)
            && $stable(o_body_length))
        else $error("stalled item changed");

    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_body_valid |-> o_status == ST_BUSY && o_body_length != '0)
        else $error("body byte with finished status or zero length");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_body_valid |-> o_body_byte == 8'd0)
        else $error("non-data item carries a byte");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_body_byte   (o_body_byte),
    .o_body_valid  (o_body_valid),
    .o_status      (o_status),
    .o_body_length (o_body_length)
);
`default_nettype wire

### tb/sv/http_chunked_body_decoder_tb.sv
module http_chunked_body_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbd_pkg::*;

    localparam int IDLE_PCT       = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0]          body_byte;
        logic                body_valid;
        logic [1:0]          status;
        logic [LEN_BITS-1:0] body_length;
    } decoded_t;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic [7:0]               i_data_byte = 8'h00;
    logic                     i_start_req = 1'b0;
    logic                     i_stall     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic                     i_cfg_idx   = CFG_MAX_BODY;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    logic                     o_stall;
    logic                     o_valid;
    logic [7:0]               o_body_byte;
    logic                     o_body_valid;
    logic [1:0]               o_status;
    logic [LEN_BITS-1:0]      o_body_length;

    // decoder state as predicted
    logic [2:0]               dec_phase;
    logic [SIZE_BITS-1:0]     dec_left;
    logic [COUNT_BITS-1:0]    dec_count;
    logic [1:0]               dec_status;
    logic                     dec_digit;
    logic                     dec_cr;
    logic [CFG_DATA_BITS-1:0] lim_max;
    logic                     lim_on;

    decoded_t   pending[$];
    logic [7:0] msg_bytes[$];
    bit         quiet = 1'b0;
    int         errors = 0;
    int         items_sent = 0;
    int         results_checked = 0;
    int         stuck_cycles = 0;
    int         ended[4] = '{0, 0, 0, 0};

    http_chunked_body_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_start_req   (i_start_req),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_body_byte   (o_body_byte),
        .o_body_valid  (o_body_valid),
        .o_status      (o_status),
        .o_body_length (o_body_length),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic clear_decoder();
        dec_phase  = PH_SIZE;
        dec_left   = '0;
        dec_count  = '0;
        dec_status = ST_BUSY;
        dec_digit  = 1'b0;
        dec_cr     = 1'b0;
    endtask

    task automatic halt(input logic [1:0] st);
        dec_status = st;
        dec_phase  = PH_STOP;
        dec_cr     = 1'b0;
    endtask

    task automatic end_size_line();
        dec_cr    = 1'b0;
        dec_digit = 1'b0;
        dec_phase = (dec_left == 0) ? PH_FINAL_END : PH_DATA;
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic start);
        decoded_t   r;
        logic [3:0] nib;
        logic       is_hex;
        logic [1:0] was;
        if (start) clear_decoder();
        was          = dec_status;
        r.body_valid = 1'b0;
        if (dec_status == ST_BUSY) begin
            case (dec_phase)
                PH_SIZE: begin
                    if (dec_cr) begin
                        if (c == CHR_LF) end_size_line();
                        else halt(ST_BAD);
                    end else if (c == CHR_CR || c == CHR_EXT) begin
                        if (!dec_digit) halt(ST_BAD);
                        else if (c == CHR_CR) dec_cr = 1'b1;
                        else dec_phase = PH_EXT;
                    end else begin
                        is_hex = 1'b1;
                        nib    = 4'd0;
                        if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
                        else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
                        else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
                        else is_hex = 1'b0;
                        if (!is_hex || dec_left[SIZE_BITS-1 -: 4] != 0) begin
                            halt(ST_BAD);
                        end else begin
                            dec_left  = {dec_left[SIZE_BITS-5:0], nib};
                            dec_digit = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    if (dec_cr && c == CHR_LF) end_size_line();
                    else dec_cr = (c == CHR_CR);
                end
                PH_DATA: begin
                    if (dec_count == '1 || (lim_on && dec_count >= lim_max)) begin
                        halt(ST_BIG);
                    end else begin
                        dec_count++;
                        r.body_valid = 1'b1;
                        dec_left--;
                        if (dec_left == 0) begin
                            dec_phase = PH_DATA_END;
                            dec_cr    = 1'b0;
                        end
                    end
                end
                PH_DATA_END, PH_FINAL_END: begin
                    if (!dec_cr) begin
                        if (c == CHR_CR) dec_cr = 1'b1;
                        else halt(ST_BAD);
                    end else if (c == CHR_LF) begin
                        dec_cr = 1'b0;
                        if (dec_phase == PH_FINAL_END) begin
                            halt(ST_DONE);
                        end else begin
                            dec_phase = PH_SIZE;
                            dec_left  = '0;
                            dec_digit = 1'b0;
                        end
                    end else begin
                        halt(ST_BAD);
                    end
                end
                default: ;
            endcase
        end
        r.body_byte   = r.body_valid ? c : 8'h00;
        r.status      = dec_status;
        r.body_length = LEN_BITS'(dec_count);
        pending.insert(pending.size(), r);
        if (was == ST_BUSY && dec_status != ST_BUSY) ended[dec_status]++;
    endtask

    always @(posedge i_clk) begin
        decoded_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                $error("unexpected item: status %0d body_length %0d", o_status, o_body_length);
                errors++;
            end else begin
                want = pending.pop_front();
                results_checked++;
                if (o_body_byte !== want.body_byte) begin
                    $error("body_byte: expected %0h, got %0h", want.body_byte, o_body_byte);
                    errors++;
                end
                if (o_body_valid !== want.body_valid) begin
                    $error("body_valid: expected %0d, got %0d", want.body_valid, o_body_valid);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_body_length !== want.body_length) begin
                    $error("body_length: expected %0d, got %0d",
                           want.body_length, o_body_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("http_chunked_body_decoder_tb: done, errors");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] c, input logic start);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= c;
        i_start_req <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(c, start);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic flush_message();
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == 0);
        msg_bytes.delete();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_MAX_BODY) lim_max = value;
        else lim_on = value[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_BITS-1:0] max_len, input logic on);
        drain();
        write_reg(CFG_MAX_BODY, max_len);
        write_reg(CFG_LIMIT_EN, CFG_DATA_BITS'(on));
    endtask

    task automatic queue_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic push_crlf();
        queue_byte(CHR_CR);
        queue_byte(CHR_LF);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // size line with random case, optional leading zeros and optional extension
    task automatic put_size(input int unsigned value);
        int unsigned ndig;
        int          i;
        logic [7:0]  b;
        ndig = 1;
        while (ndig < 8 && (value >> (4 * ndig)) != 0) ndig++;
        if ($urandom_range(0, 3) == 0) ndig += $urandom_range(1, 2);
        for (i = int'(ndig) - 1; i >= 0; i--) begin
            queue_byte(hex_char(4'(value >> (4 * i)), 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 4) == 0) begin
            queue_byte(CHR_EXT);
            repeat ($urandom_range(0, 6)) begin
                b = 8'($urandom_range(0, 255));
                queue_byte(b);
                if (b == CHR_CR) queue_byte(8'h2E);
            end
        end
        push_crlf();
    endtask

    task automatic send_message();
        int unsigned len;
        int unsigned mode;
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
            put_size(len);
            repeat (len) queue_byte(8'($urandom_range(0, 255)));
            push_crlf();
        end
        put_size(0);
        push_crlf();
        mode = $urandom_range(0, 99);
        if (mode < 8) begin
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (mode < 14) begin
            repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
        end else if (mode < 18) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
        end
        flush_message();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic run_messages(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_message();
        end
    endtask

    task automatic test_framing();
        push_text("1");
        push_crlf();
        queue_byte(8'hFF);
        push_crlf();
        push_text("0");
        push_crlf();
        push_crlf();
        push_text("x");
        flush_message();
        // empty size, then a byte that must be ignored
        push_text(";x");
        flush_message();
        // lone CR inside the extension, then missing CRLF after the data
        push_text("1;a");
        queue_byte(CHR_CR);
        push_text("z");
        push_crlf();
        queue_byte(8'h00);
        push_text("q");
        flush_message();
        push_text("A");
        queue_byte(CHR_CR);
        push_text(";");
        flush_message();
        push_text("100000000");
        flush_message();
    endtask

    task automatic test_default_limit();
        set_limits(MAX_BODY_RESET, 1'b1);
        run_messages(400);
    endtask

    task automatic test_tight_limit_back_to_back();
        set_limits(40, 1'b1);
        quiet = 1'b1;
        run_messages(250);
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_widest_limit();
        set_limits('1, 1'b1);
        run_messages(250);
    endtask

    task automatic test_limit_disabled();
        set_limits(3, 1'b0);
        run_messages(250);
    endtask

    task automatic test_zero_limit();
        set_limits('0, 1'b1);
        run_messages(80);
    endtask

    task automatic test_random_limit();
        set_limits($urandom_range(1, 100), 1'b1);
        run_messages(200);
    endtask

    initial begin
        clear_decoder();
        lim_max = MAX_BODY_RESET;
        lim_on  = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_framing();
        test_default_limit();
        test_tight_limit_back_to_back();
        test_widest_limit();
        test_limit_disabled();
        test_zero_limit();
        test_random_limit();
        drain();
        repeat (3) @(negedge i_clk);
        $display("covered %0d input items and %0d checked results over six limit settings",
                 items_sent, results_checked);
        $display("messages ended: %0d complete, %0d too large, %0d malformed",
                 ended[ST_DONE], ended[ST_BIG], ended[ST_BAD]);
        if (errors == 0) begin
            $display("http_chunked_body_decoder_tb: done, clean");
        end else begin
            $display("http_chunked_body_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule
